FILE: design/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, result codes and helper functions of the JSON string
// unescape unit.
// ----------------------------------------------------------------------------
package jsu_pkg;

	localparam int MAX_RESULTS = 6;
	localparam int RES_IDX_W = 3;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [2:0] K_BYTE = 3'd0;
	localparam logic [2:0] K_CLOSED = 3'd1;
	localparam logic [2:0] K_NOQUOTE = 3'd2;
	localparam logic [2:0] K_UNTERM = 3'd3;
	localparam logic [2:0] K_TRUNC = 3'd4;
	localparam logic [2:0] K_BADHEX = 3'd5;
	localparam logic [2:0] K_UNKNOWN = 3'd6;

	typedef struct packed {
		logic [7:0] byte_val;
		logic [2:0] kind;
	} result_t;

	// All results caused by one input byte, in emission order.
	typedef struct packed {
		logic [RES_IDX_W-1:0] n;
		result_t [MAX_RESULTS-1:0] res;
	} plan_t;

	typedef struct packed {
		logic ok;
		logic [3:0] val;
	} hex_t;

	typedef struct packed {
		logic [2:0] n;
		logic [3:0][7:0] b;
	} utf8_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h.ok = 1'b1;
		h.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.val = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			h.val = c[3:0] + 4'd9;
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

	function automatic utf8_t utf8_encode(input logic [20:0] cp);
		utf8_t u;
		u.b = '0;
		if (cp < 21'h80) begin
			u.n = 3'd1;
			u.b[0] = cp[7:0];
		end else if (cp < 21'h800) begin
			u.n = 3'd2;
			u.b[0] = {3'b110, cp[10:6]};
			u.b[1] = {2'b10, cp[5:0]};
		end else if (cp < 21'h10000) begin
			u.n = 3'd3;
			u.b[0] = {4'b1110, cp[15:12]};
			u.b[1] = {2'b10, cp[11:6]};
			u.b[2] = {2'b10, cp[5:0]};
		end else begin
			u.n = 3'd4;
			u.b[0] = {5'b11110, cp[20:18]};
			u.b[1] = {2'b10, cp[17:12]};
			u.b[2] = {2'b10, cp[11:6]};
			u.b[3] = {2'b10, cp[5:0]};
		end
		return u;
	endfunction

endpackage

FILE: design/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Parser state machine: takes one byte per transfer, updates the escape and
// surrogate state and builds the list of results that the byte causes.
// ----------------------------------------------------------------------------
module jsu_front import jsu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  in_byte,
	input  logic [2:0]  bytes_after,
	output plan_t       plan
);

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_BODY = 3'd1;
	localparam logic [2:0] PH_ESC = 3'd2;
	localparam logic [2:0] PH_HEX = 3'd3;
	localparam logic [2:0] PH_LA_BS = 3'd4;
	localparam logic [2:0] PH_LA_U = 3'd5;
	localparam logic [2:0] PH_LA_HEX = 3'd6;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B = 8'h62;
	localparam logic [7:0] CH_F = 8'h66;
	localparam logic [7:0] CH_N = 8'h6E;
	localparam logic [7:0] CH_R = 8'h72;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_U = 8'h75;

	logic [2:0]  ph_q, ph_n;
	logic [15:0] acc_q, acc_n;
	logic [15:0] hh_q, hh_n;
	logic [1:0]  dc_q, dc_n;

	logic              pre;
	logic              unterm;
	logic [2:0]        main_n;
	logic [3:0][7:0]   main_b;
	logic [3:0][2:0]   main_k;
	logic [2:0][7:0]   hh_b;

	hex_t        hx;
	logic [15:0] acc_sh;
	logic [10:0] hi_plane;
	utf8_t       enc_single;
	utf8_t       enc_pair;

	assign hx = hex_decode(in_byte);
	assign acc_sh = {acc_q[11:0], hx.val};
	assign hi_plane = {1'b0, hh_q[9:0]} + 11'h040;
	assign enc_single = utf8_encode({5'd0, acc_sh});
	assign enc_pair = utf8_encode({hi_plane[10:0], acc_sh[9:0]});

	// A held high surrogate always encodes as three bytes.
	assign hh_b[0] = {4'b1110, hh_q[15:12]};
	assign hh_b[1] = {2'b10, hh_q[11:6]};
	assign hh_b[2] = {2'b10, hh_q[5:0]};

	always_comb begin
		logic do_body;
		logic do_esc;
		ph_n = ph_q;
		acc_n = acc_q;
		hh_n = hh_q;
		dc_n = dc_q;
		pre = 1'b0;
		unterm = 1'b0;
		main_n = 3'd0;
		main_b = '0;
		main_k = '0;
		do_body = 1'b0;
		do_esc = 1'b0;

		case (ph_q)
			PH_BODY: begin
				do_body = 1'b1;
			end
			PH_ESC: begin
				do_esc = 1'b1;
			end
			PH_HEX: begin
				if (!hx.ok) begin
					main_n = 3'd1;
					main_k[0] = K_BADHEX;
					ph_n = PH_IDLE;
					dc_n = 2'd0;
				end else begin
					acc_n = acc_sh;
					dc_n = dc_q + 2'd1;
					if (dc_q == 2'd3) begin
						if (acc_sh >= 16'hD800 && acc_sh <= 16'hDBFF && bytes_after >= 3'd6) begin
							hh_n = acc_sh;
							ph_n = PH_LA_BS;
						end else begin
							main_n = enc_single.n;
							main_b = enc_single.b;
							ph_n = PH_BODY;
						end
					end
				end
			end
			PH_LA_BS: begin
				if (in_byte == CH_BSLASH) begin
					ph_n = PH_LA_U;
				end else begin
					pre = 1'b1;
					ph_n = PH_BODY;
					do_body = 1'b1;
				end
			end
			PH_LA_U: begin
				if (in_byte == CH_U) begin
					ph_n = PH_LA_HEX;
					acc_n = 16'd0;
					dc_n = 2'd0;
				end else begin
					pre = 1'b1;
					do_esc = 1'b1;
				end
			end
			PH_LA_HEX: begin
				if (!hx.ok) begin
					pre = 1'b1;
					main_n = 3'd1;
					main_k[0] = K_BADHEX;
					ph_n = PH_IDLE;
					dc_n = 2'd0;
				end else begin
					acc_n = acc_sh;
					dc_n = dc_q + 2'd1;
					// The second escape cannot be a low surrogate: release the
					// high half and carry on reading it as an ordinary escape.
					if ((dc_q == 2'd0 && hx.val != 4'hD) || (dc_q == 2'd1 && hx.val < 4'hC)) begin
						pre = 1'b1;
						ph_n = PH_HEX;
					end else if (dc_q == 2'd3) begin
						main_n = enc_pair.n;
						main_b = enc_pair.b;
						ph_n = PH_BODY;
					end
				end
			end
			default: begin
				if (in_byte == CH_QUOTE) begin
					ph_n = PH_BODY;
				end else begin
					main_n = 3'd1;
					main_k[0] = K_NOQUOTE;
					ph_n = PH_IDLE;
					dc_n = 2'd0;
				end
			end
		endcase

		if (do_body) begin
			if (in_byte == CH_QUOTE) begin
				main_n = 3'd1;
				main_k[0] = K_CLOSED;
				ph_n = PH_IDLE;
				dc_n = 2'd0;
			end else if (in_byte == CH_BSLASH) begin
				ph_n = PH_ESC;
			end else begin
				main_n = 3'd1;
				main_b[0] = in_byte;
			end
		end

		if (do_esc) begin
			ph_n = PH_BODY;
			main_n = 3'd1;
			case (in_byte)
				CH_QUOTE: main_b[0] = CH_QUOTE;
				CH_BSLASH: main_b[0] = CH_BSLASH;
				CH_SLASH: main_b[0] = CH_SLASH;
				CH_B: main_b[0] = 8'h08;
				CH_F: main_b[0] = 8'h0C;
				CH_N: main_b[0] = 8'h0A;
				CH_R: main_b[0] = 8'h0D;
				CH_T: main_b[0] = 8'h09;
				CH_U: begin
					if (bytes_after < 3'd4) begin
						main_k[0] = K_TRUNC;
						ph_n = PH_IDLE;
						dc_n = 2'd0;
					end else begin
						main_n = 3'd0;
						ph_n = PH_HEX;
						acc_n = 16'd0;
						dc_n = 2'd0;
					end
				end
				default: begin
					main_k[0] = K_UNKNOWN;
					ph_n = PH_IDLE;
					dc_n = 2'd0;
				end
			endcase
		end

		// Text ends while the string is still open.
		if (ph_n != PH_IDLE && bytes_after == 3'd0) begin
			if (ph_n == PH_LA_BS || ph_n == PH_LA_U || ph_n == PH_LA_HEX) begin
				pre = 1'b1;
			end
			unterm = 1'b1;
			ph_n = PH_IDLE;
			dc_n = 2'd0;
		end
	end

	// Pack the held high surrogate, the main results and the end status.
	always_comb begin
		logic [3:0] j;
		logic [3:0] total;
		plan.res = '0;
		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (pre && i < 3) begin
				plan.res[i].byte_val = hh_b[i];
				plan.res[i].kind = K_BYTE;
			end else begin
				j = pre ? 4'(i - 3) : 4'(i);
				if (j < {1'b0, main_n}) begin
					plan.res[i].byte_val = main_b[j[1:0]];
					plan.res[i].kind = main_k[j[1:0]];
				end else if (j == {1'b0, main_n} && unterm) begin
					plan.res[i].kind = K_UNTERM;
				end
			end
		end
		total = (pre ? 4'd3 : 4'd0) + {1'b0, main_n} + {3'd0, unterm};
		plan.n = (total > 4'(MAX_RESULTS)) ? RES_IDX_W'(MAX_RESULTS) : total[RES_IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
			acc_q <= 16'd0;
			hh_q <= 16'd0;
			dc_q <= 2'd0;
		end else if (accept) begin
			ph_q <= ph_n;
			acc_q <= acc_n;
			hh_q <= hh_n;
			dc_q <= dc_n;
		end
	end

endmodule

FILE: design/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Short first-in first-out queue of result lists between the parser and the
// output sequencer.
// ----------------------------------------------------------------------------
module jsu_queue import jsu_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  plan_t push_plan,
	input  logic  pop,
	output logic  full,
	output logic  not_empty,
	output plan_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	plan_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full = (cnt_q == CNT_W'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_plan;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

FILE: design/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Output sequencer: walks the result list at the head of the queue, one
// result per transfer, and marks the last one of each input byte.
// ----------------------------------------------------------------------------
module jsu_back import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  plan_t      head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [2:0] kind,
	output logic       last_of_run
);

	logic [RES_IDX_W-1:0] idx_q;
	logic                 fire;

	assign out_valid = head_valid;
	assign out_byte = head.res[idx_q].byte_val;
	assign kind = head.res[idx_q].kind;
	assign last_of_run = (idx_q == head.n - RES_IDX_W'(1));
	assign fire = out_valid && out_ready;
	assign pop = fire && last_of_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (fire) begin
			idx_q <= last_of_run ? '0 : idx_q + RES_IDX_W'(1);
		end
	end

endmodule

FILE: design/json_string_unescape_utf8_unit.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_unit
// Unescapes a quoted JSON string byte by byte and emits UTF-8 bytes followed
// by one status code per string.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Payload
//  input   | in_valid / in_ready  | in_byte[7:0], bytes_after[2:0]
//  output  | out_valid / out_ready| out_byte[7:0], kind[2:0], last_of_run
//
// One input byte is taken per cycle while the result queue has room; the
// parser updates its state in the cycle of the transfer.
// Each input byte yields zero to six results, sent one per cycle by the
// output sequencer while out_ready is high. Reset returns the parser to
// waiting for an opening quote and empties the queue. A stalled output
// fills the queue and then drops in_ready.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_unit import jsu_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic [2:0] bytes_after,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [2:0] kind,
	output logic       last_of_run
);

	logic  accept;
	logic  q_full;
	logic  q_not_empty;
	logic  q_pop;
	plan_t plan;
	plan_t head;

	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;

	jsu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.in_byte     (in_byte),
		.bytes_after (bytes_after),
		.plan        (plan)
	);

	// Bytes that cause no result never enter the queue.
	jsu_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && plan.n != '0),
		.push_plan (plan),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head)
	);

	jsu_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (q_not_empty),
		.head        (head),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.kind        (kind),
		.last_of_run (last_of_run)
	);

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the JSON string unescape unit. Quoted strings with
// random content (plain bytes, short escapes, backslash-u escapes, surrogate
// pairs, broken look-aheads and malformed escapes) are fed one byte per
// transfer while both channels stall at random. A scoreboard predicts every
// result byte and status and compares them in order.
// ----------------------------------------------------------------------------
import jsu_pkg::*;

localparam logic [7:0] CH_QUOTE = 8'h22;
localparam logic [7:0] CH_BSLASH = 8'h5C;

typedef enum logic [3:0] {
	ST_WAIT_QUOTE,
	ST_TEXT,
	ST_ESCAPE,
	ST_HEX,
	ST_PEEK_BACKSLASH,
	ST_PEEK_U,
	ST_PEEK_HEX
} scan_state_t;

typedef struct packed {
	logic [7:0] data;
	logic [2:0] kind;
	logic last;
} out_item_t;

function automatic int hex_digit_value(input logic [7:0] c);
	if (c >= "0" && c <= "9") return c - "0";
	if (c >= "a" && c <= "f") return c - "a" + 10;
	if (c >= "A" && c <= "F") return c - "A" + 10;
	return -1;
endfunction

class unescape_scoreboard;
	scan_state_t state;
	logic [15:0] hex_word;
	logic [15:0] held_high;
	logic [2:0] digits;
	out_item_t run_q[$];
	out_item_t awaited_q[$];
	int checked;
	int mismatches;
	int kind_count[8];

	function new();
		state = ST_WAIT_QUOTE;
		hex_word = '0;
		held_high = '0;
		digits = '0;
		checked = 0;
		mismatches = 0;
		foreach (kind_count[i]) kind_count[i] = 0;
	endfunction

	function int pending();
		return awaited_q.size();
	endfunction

	function void emit(logic [7:0] b, logic [2:0] k);
		out_item_t it;
		if (run_q.size() >= MAX_RESULTS) return;
		it.data = b;
		it.kind = k;
		it.last = 1'b0;
		run_q = {run_q, it};
	endfunction

	function void emit_utf8(logic [20:0] cp);
		if (cp < 21'h80) begin
			emit(cp[7:0], K_BYTE);
		end else if (cp < 21'h800) begin
			emit(8'hC0 | 8'(cp >> 6), K_BYTE);
			emit(8'h80 | 8'(cp & 21'h3F), K_BYTE);
		end else if (cp < 21'h10000) begin
			emit(8'hE0 | 8'(cp >> 12), K_BYTE);
			emit(8'h80 | 8'((cp >> 6) & 21'h3F), K_BYTE);
			emit(8'h80 | 8'(cp & 21'h3F), K_BYTE);
		end else begin
			emit(8'hF0 | 8'((cp >> 18) & 21'h7), K_BYTE);
			emit(8'h80 | 8'((cp >> 12) & 21'h3F), K_BYTE);
			emit(8'h80 | 8'((cp >> 6) & 21'h3F), K_BYTE);
			emit(8'h80 | 8'(cp & 21'h3F), K_BYTE);
		end
	endfunction

	function void abort(logic [2:0] k);
		emit(8'h00, k);
		state = ST_WAIT_QUOTE;
		digits = '0;
	endfunction

	function void text_byte(logic [7:0] c);
		if (c == CH_QUOTE) abort(K_CLOSED);
		else if (c == CH_BSLASH) state = ST_ESCAPE;
		else emit(c, K_BYTE);
	endfunction

	function void escape_byte(logic [7:0] c, logic [2:0] after);
		state = ST_TEXT;
		case (c)
			CH_QUOTE, CH_BSLASH, "/": emit(c, K_BYTE);
			"b": emit(8'h08, K_BYTE);
			"f": emit(8'h0C, K_BYTE);
			"n": emit(8'h0A, K_BYTE);
			"r": emit(8'h0D, K_BYTE);
			"t": emit(8'h09, K_BYTE);
			"u": begin
				if (after < 3'd4) begin
					abort(K_TRUNC);
				end else begin
					state = ST_HEX;
					hex_word = '0;
					digits = '0;
				end
			end
			default: abort(K_UNKNOWN);
		endcase
	endfunction

	function void hex_byte(logic [7:0] c, logic [2:0] after);
		int v;
		v = hex_digit_value(c);
		if (v < 0) begin
			abort(K_BADHEX);
			return;
		end
		hex_word = {hex_word[11:0], 4'(v)};
		digits = digits + 3'd1;
		if (digits < 3'd4) return;
		digits = '0;
		// A high surrogate with room for a second escape is held back.
		if (hex_word >= 16'hD800 && hex_word <= 16'hDBFF && after >= 3'd6) begin
			held_high = hex_word;
			state = ST_PEEK_BACKSLASH;
		end else begin
			emit_utf8({5'd0, hex_word});
			state = ST_TEXT;
		end
	endfunction

	function void peek_hex_byte(logic [7:0] c);
		int v;
		v = hex_digit_value(c);
		if (v < 0) begin
			emit_utf8({5'd0, held_high});
			abort(K_BADHEX);
			return;
		end
		hex_word = {hex_word[11:0], 4'(v)};
		digits = digits + 3'd1;
		// Once the digits cannot form a low surrogate, the held half goes out
		// alone and the digits read so far continue as an ordinary escape.
		if ((digits == 3'd1 && v != 'hD) || (digits == 3'd2 && v < 'hC)) begin
			emit_utf8({5'd0, held_high});
			state = ST_HEX;
			return;
		end
		if (digits < 3'd4) return;
		digits = '0;
		emit_utf8(21'h10000 + {1'b0, held_high[9:0], 10'd0} + {11'd0, hex_word[9:0]});
		state = ST_TEXT;
	endfunction

	function void note_byte(logic [7:0] c, logic [2:0] after);
		run_q.delete();
		case (state)
			ST_TEXT: text_byte(c);
			ST_ESCAPE: escape_byte(c, after);
			ST_HEX: hex_byte(c, after);
			ST_PEEK_BACKSLASH: begin
				if (c == CH_BSLASH) begin
					state = ST_PEEK_U;
				end else begin
					emit_utf8({5'd0, held_high});
					state = ST_TEXT;
					text_byte(c);
				end
			end
			ST_PEEK_U: begin
				if (c == "u") begin
					state = ST_PEEK_HEX;
					hex_word = '0;
					digits = '0;
				end else begin
					emit_utf8({5'd0, held_high});
					escape_byte(c, after);
				end
			end
			ST_PEEK_HEX: peek_hex_byte(c);
			default: begin
				if (c == CH_QUOTE) state = ST_TEXT;
				else abort(K_NOQUOTE);
			end
		endcase
		if (state != ST_WAIT_QUOTE && after == 3'd0) begin
			if (state == ST_PEEK_BACKSLASH || state == ST_PEEK_U || state == ST_PEEK_HEX)
				emit_utf8({5'd0, held_high});
			abort(K_UNTERM);
		end
		if (run_q.size() > 0) run_q[run_q.size() - 1].last = 1'b1;
		awaited_q = {awaited_q, run_q};
	endfunction

	function void check_result(logic [7:0] b, logic [2:0] k, logic l);
		out_item_t want;
		checked++;
		if (k <= 3'd6) kind_count[k]++;
		if (awaited_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: byte %02h kind %0d last %0d, none pending",
					b, k, l);
			return;
		end
		want = awaited_q.pop_front();
		if (want.data !== b || want.kind !== k || want.last !== l) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch at result %0d: expected %02h/%0d/%0d, got %02h/%0d/%0d",
					checked, want.data, want.kind, want.last, b, k, l);
		end
	endfunction
endclass

module tb_top;

	localparam int LONG_HOLD = 120;
	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_BYTES = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] in_byte = 8'h00;
	logic [2:0] bytes_after = 3'd0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] out_byte;
	logic [2:0] kind;
	logic last_of_run;

	unescape_scoreboard board;
	int cycle_count = 0;
	int bytes_sent = 0;
	int strings_sent = 0;
	bit hold_request = 1'b0;
	bit sender_calm = 1'b0;
	logic [7:0] text_q[$];
	string esc_chars = "\"\\/bfnrt";

	json_string_unescape_utf8_unit dut (.*);

	always #1 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do b = 8'($urandom); while (b == CH_QUOTE || b == CH_BSLASH);
		return b;
	endfunction

	function automatic logic [7:0] non_hex_byte();
		logic [7:0] b;
		do b = 8'($urandom); while (hex_digit_value(b) >= 0);
		return b;
	endfunction

	function automatic logic [7:0] unknown_escape_byte();
		logic [7:0] b;
		bit hit;
		do begin
			b = 8'($urandom);
			hit = (b == "u");
			for (int i = 0; i < esc_chars.len(); i++)
				if (esc_chars[i] == b) hit = 1'b1;
		end while (hit);
		return b;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		logic [7:0] base;
		if (v < 4'd10) return 8'h30 + {4'h0, v};
		base = $urandom_range(0, 1) ? "a" : "A";
		return base + {4'h0, v - 4'd10};
	endfunction

	function automatic void put_text(input logic [7:0] b);
		text_q = {text_q, b};
	endfunction

	function automatic void push_u_escape(input logic [15:0] cp);
		put_text(CH_BSLASH);
		put_text("u");
		for (int i = 3; i >= 0; i--) put_text(hex_char(cp[4*i +: 4]));
	endfunction

	function automatic logic [15:0] random_code();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 'h7F));
			1: return 16'($urandom_range('h80, 'h7FF));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void add_token();
		int r;
		logic [15:0] hi;
		logic [3:0] nib;
		logic [15:0] edge_codes[10];
		edge_codes = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800,
			16'hFFFF, 16'hD800, 16'hDBFF, 16'hDC00, 16'hDFFF};
		r = $urandom_range(0, 99);
		hi = 16'hD800 | 16'($urandom_range(0, 'h3FF));
		if (r < 34) begin
			put_text(plain_byte());
		end else if (r < 48) begin
			put_text(CH_BSLASH);
			put_text(esc_chars[$urandom_range(0, 7)]);
		end else if (r < 62) begin
			push_u_escape(random_code());
		end else if (r < 74) begin
			push_u_escape(hi);
			push_u_escape(16'hDC00 | 16'($urandom_range(0, 'h3FF)));
		end else if (r < 85) begin
			// High surrogate followed by something that breaks the pair.
			push_u_escape(hi);
			case ($urandom_range(0, 5))
				0: put_text(plain_byte());
				1: begin
					put_text(CH_BSLASH);
					put_text(esc_chars[$urandom_range(0, 7)]);
				end
				2: begin
					nib = 4'($urandom_range(0, 14));
					if (nib >= 4'hD) nib++;
					push_u_escape({nib, 12'($urandom)});
				end
				3: begin
					put_text(CH_BSLASH);
					put_text("u");
					put_text(hex_char(4'hD));
					put_text(hex_char(4'($urandom_range(0, 11))));
					put_text(hex_char(4'($urandom)));
					put_text(hex_char(4'($urandom)));
				end
				4: begin
					put_text(CH_BSLASH);
					put_text("u");
					put_text(hex_char(4'hD));
					put_text(non_hex_byte());
				end
				default: begin
					put_text(CH_BSLASH);
					put_text("u");
					put_text(non_hex_byte());
				end
			endcase
		end else if (r < 90) begin
			put_text(CH_BSLASH);
			put_text("u");
			repeat ($urandom_range(0, 3)) put_text(hex_char(4'($urandom)));
			put_text(non_hex_byte());
		end else if (r < 94) begin
			put_text(CH_BSLASH);
			put_text(unknown_escape_byte());
		end else begin
			push_u_escape(edge_codes[$urandom_range(0, 9)]);
		end
	endfunction

	function automatic void build_string();
		text_q.delete();
		if ($urandom_range(0, 19) == 0) put_text(plain_byte());
		put_text(CH_QUOTE);
		repeat ($urandom_range(0, 5)) add_token();
		if ($urandom_range(0, 9) != 0) put_text(CH_QUOTE);
	endfunction

	// This task lowers valid only when a gap is taken, so back-to-back transfers
	// never see two assignments to it in one time step.
	task automatic send_byte(input logic [7:0] b, input logic [2:0] cnt);
		int gap;
		gap = sender_calm ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		bytes_after <= cnt;
		do @(posedge clk); while (in_ready !== 1'b1);
		board.note_byte(b, cnt);
		bytes_sent++;
	endtask

	task automatic send_literal(input string s);
		int rem;
		for (int i = 0; i < s.len(); i++) begin
			rem = s.len() - 1 - i;
			send_byte(s[i], (rem > 7) ? 3'd7 : 3'(rem));
		end
	endtask

	task automatic send_text();
		bit skew;
		int rem;
		logic [2:0] cnt;
		skew = ($urandom_range(0, 6) == 0);
		sender_calm = ($urandom_range(0, 3) == 0);
		foreach (text_q[i]) begin
			rem = text_q.size() - 1 - i;
			cnt = (rem > 7) ? 3'd7 : 3'(rem);
			if (skew && $urandom_range(0, 4) == 0) cnt = 3'($urandom_range(0, 7));
			send_byte(text_q[i], cnt);
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending() > 0) @(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready)
			board.check_result(out_byte, kind, last_of_run);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending",
				cycle_count, board.pending());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin : receiver
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = 0;
			if (hold_request) begin
				hold_request = 1'b0;
				stall = LONG_HOLD;
			end else if ($urandom_range(0, 29) == 0) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(20, 50)) @(negedge clk);
			end else begin
				stall = pick_gap();
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	initial begin : stimulus
		int random_start;
		board = new();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_byte(8'hFF, 3'd0);
		send_literal("\"\\uDBFF\\u0041\"");
		// Count drops to zero in the middle of an escape.
		send_byte(CH_QUOTE, 3'd7);
		send_byte(CH_BSLASH, 3'd7);
		send_byte("u", 3'd4);
		send_byte("1", 3'd0);
		send_literal("\"\\q");
		send_literal("\"\\u");
		send_byte(CH_QUOTE, 3'd1);
		send_byte(8'h00, 3'd0);
		drain_results();

		hold_request = 1'b1;
		random_start = bytes_sent;
		while (bytes_sent - random_start < RANDOM_BYTES) begin
			build_string();
			send_text();
			strings_sent++;
			if (strings_sent == 25) hold_request = 1'b1;
			if ($urandom_range(0, 11) == 0) drain_results();
		end
		sender_calm = 1'b0;
		drain_results();
		repeat (20) @(posedge clk);

		$display("Sent %0d bytes (%0d random strings) and checked %0d results in %0d cycles.",
			bytes_sent, strings_sent, board.checked, cycle_count);
		$display("Statuses: closed %0d, no quote %0d, unterminated %0d, truncated %0d,",
			board.kind_count[K_CLOSED], board.kind_count[K_NOQUOTE],
			board.kind_count[K_UNTERM], board.kind_count[K_TRUNC]);
		$display("  bad hex %0d, unknown escape %0d; mismatches %0d.",
			board.kind_count[K_BADHEX], board.kind_count[K_UNKNOWN], board.mismatches);
		if (board.mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
